// File: rtl/core/aba_pkg.sv
// Shared types and constants of the arena block allocator.
`timescale 1ns / 1ps
package aba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 32;
  localparam int unsigned SLOT_W         = 8;
  localparam int unsigned OFS_W          = 16;
  localparam int unsigned TOTAL_W        = 48;

  localparam logic [15:0] BLOCK_SIZE_RST = 16'd2040;
  localparam logic [15:0] SLOP_RST       = 16'd16;
  localparam logic [8:0]  ALIGN_RST      = 9'd8;

  localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] REG_SLOP       = 2'd1;
  localparam logic [1:0] REG_ALIGN      = 2'd2;

  // One list entry: a block slot and its bookkeeping.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [OFS_W-1:0]  ofs;
    logic [OFS_W-1:0]  rem;
    logic              std;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_POP,
    OP_ROTATE,
    OP_APPEND
  } chain_op_e;

  typedef struct packed {
    chain_op_e op;
    entry_t    inj;
  } chain_ctl_t;

endpackage

// File: rtl/core/aba_cell.sv
// One list cell: holds an entry and takes it from a neighbor or the injected entry.
`timescale 1ns / 1ps
module aba_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned LenW = 6
) (
  input  logic                clk_i,
  input  aba_pkg::chain_ctl_t ctl_i,
  input  logic [LenW-1:0]     len_i,
  input  aba_pkg::entry_t     left_i,
  input  aba_pkg::entry_t     right_i,
  output aba_pkg::entry_t     ent_o
);
  import aba_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.op)
      OP_PUSH_FRONT: ent_d = left_i;
      OP_POP:        ent_d = right_i;
      OP_ROTATE: begin
        if (LenW'(Idx) == len_i - LenW'(1)) ent_d = ctl_i.inj;
        else ent_d = right_i;
      end
      OP_APPEND: begin
        if (LenW'(Idx) == len_i) ent_d = ctl_i.inj;
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// File: rtl/core/aba_chain.sv
// A list kept as a row of cells plus its length register.
`timescale 1ns / 1ps
module aba_chain #(
  parameter int unsigned NumCells = aba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned LenW     = $clog2(NumCells + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aba_pkg::chain_ctl_t ctl_i,
  output aba_pkg::entry_t     head_o,
  output logic [LenW-1:0]     len_o,
  output logic [LenW-1:0]     len_next_o
);
  import aba_pkg::*;

  entry_t          ent_w   [NumCells];
  entry_t          left_w  [NumCells];
  entry_t          right_w [NumCells];
  logic [LenW-1:0] len_q, len_d;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = ctl_i.inj;
    end else begin : g_mid
      assign left_w[i] = ent_w[i-1];
    end
    if (i == NumCells - 1) begin : g_last
      assign right_w[i] = ctl_i.inj;
    end else begin : g_inner
      assign right_w[i] = ent_w[i+1];
    end
    aba_cell #(
      .Idx  (i),
      .LenW (LenW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .len_i   (len_q),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .ent_o   (ent_w[i])
    );
  end

  always_comb begin
    len_d = len_q;
    case (ctl_i.op)
      OP_PUSH_FRONT, OP_APPEND: len_d = len_q + LenW'(1);
      OP_POP:                   len_d = len_q - LenW'(1);
      default:                  len_d = len_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign head_o     = ent_w[0];
  assign len_o      = len_q;
  assign len_next_o = len_d;

endmodule

// File: rtl/core/arena_block_allocator_top.sv
// Top level of the arena block allocator: control, config registers and result register.
`timescale 1ns / 1ps
// An allocate runs a 16-step alignment remainder, a sizing step, a scan over every slot and a
//   placing step that waits for a free result register, then returns to idle for the next beat;
//   an oversized one skips the remainder and sizing.
// A release appends the full list to the free list, walks it and moves the kept blocks back.
// Throughput: one item at a time, set by the scan that rotates the free list one cell a cycle.
// Reset clears list lengths, slot usage, the byte total and loads the default config.
module arena_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = aba_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] request_bytes_i,
  input  logic [8:0]  keep_blocks_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [7:0]  block_slot_o,
  output logic [15:0] byte_offset_o,
  output logic        is_large_o,
  output logic [8:0]  free_count_o,
  output logic [8:0]  full_count_o,
  output logic [47:0] allocated_total_o
);
  import aba_pkg::*;

  localparam int unsigned SW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned LENW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_ROUND    = 9'b000000010,
    ST_SIZE     = 9'b000000100,
    ST_SCAN     = 9'b000001000,
    ST_PLACE    = 9'b000010000,
    ST_REL_A    = 9'b000100000,
    ST_REL_B    = 9'b001000000,
    ST_REL_C    = 9'b010000000,
    ST_REL_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [15:0] bs_q, slop_q;
  logic [8:0]  align_q;
  logic        cfg_wr;

  // per-item working registers
  logic [31:0]      raw_q, raw_d;
  logic [16:0]      size_q, size_d;
  logic             large_q, large_d;
  logic [9:0]       rem_q, rem_d;
  logic [15:0]      div_sh_q, div_sh_d;
  logic [3:0]       div_cnt_q, div_cnt_d;
  logic [8:0]       keep_q, keep_d;
  logic [LENW-1:0]  cnt_q, cnt_d;
  logic [LENW-1:0]  len0_q, len0_d;
  logic             hit_q, hit_d;
  logic             hit_full_q, hit_full_d;
  entry_t           hit_ent_q, hit_ent_d;
  logic [15:0]      hit_ofs_q, hit_ofs_d;
  logic             found_q, found_d;
  logic [SW-1:0]    unused_q, unused_d;

  logic [MAX_BLOCKS-1:0] in_use_q, in_use_d;
  logic [47:0]           total_q, total_d;

  // result register
  logic        out_valid_q, out_valid_d, out_load;
  logic        res_ok;
  logic [7:0]  res_slot;
  logic [15:0] res_ofs;
  logic        res_large;
  logic [8:0]  res_free, res_full;
  logic        ok_q;
  logic [7:0]  slot_q;
  logic [15:0] ofs_q;
  logic        large_out_q;
  logic [8:0]  free_cnt_q, full_cnt_q;
  logic [47:0] total_out_q;

  // list chains
  chain_ctl_t      free_ctl, full_ctl;
  entry_t          free_head, full_head;
  logic [LENW-1:0] free_len, full_len, free_len_nx, full_len_nx;

  aba_chain #(
    .NumCells (MAX_BLOCKS),
    .LenW     (LENW)
  ) u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (free_ctl),
    .head_o     (free_head),
    .len_o      (free_len),
    .len_next_o (free_len_nx)
  );

  aba_chain #(
    .NumCells (MAX_BLOCKS),
    .LenW     (LENW)
  ) u_full (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (full_ctl),
    .head_o     (full_head),
    .len_o      (full_len),
    .len_next_o (full_len_nx)
  );

  // ---------------------------------------------------------------------------------------
  // Config port: writes land on the access beat; pready is tied high.
  // ---------------------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q    <= BLOCK_SIZE_RST;
      slop_q  <= SLOP_RST;
      align_q <= ALIGN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BLOCK_SIZE: bs_q    <= pwdata[15:0];
        REG_SLOP:       slop_q  <= pwdata[15:0];
        REG_ALIGN:      align_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BLOCK_SIZE: prdata = {16'd0, bs_q};
      REG_SLOP:       prdata = {16'd0, slop_q};
      REG_ALIGN:      prdata = {23'd0, align_q};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------------------
  logic        in_acc, out_free;
  logic [8:0]  al;
  logic [9:0]  div_t;
  logic        big;
  logic [48:0] sum;
  logic [47:0] total_add;
  logic [15:0] new_rem, new_ofs, std_rem;
  entry_t      mod_ent, kept_ent;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // A result may load when the register is empty or its beat is taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;

  assign al    = (align_q == 9'd0) ? 9'd1 : align_q;
  assign div_t = {rem_q[8:0], div_sh_q[15]};
  assign big   = large_q || (size_q > {1'b0, bs_q});

  assign sum       = {1'b0, total_q} + 49'(raw_q);
  assign total_add = sum[48] ? '1 : sum[47:0];

  // First-fit candidate at the free-list head, with its offset advanced and its remainder reduced.
  assign new_rem = free_head.rem - size_q[15:0];
  assign new_ofs = free_head.ofs + size_q[15:0];
  always_comb begin
    mod_ent     = free_head;
    mod_ent.rem = new_rem;
    mod_ent.ofs = new_ofs;
  end

  // Kept blocks restart empty at the current block size.
  always_comb begin
    kept_ent      = free_head;
    kept_ent.ofs  = '0;
    kept_ent.rem  = bs_q;
    kept_ent.std  = 1'b1;
  end

  assign std_rem = bs_q - size_q[15:0];

  // ---------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    raw_d       = raw_q;
    size_d      = size_q;
    large_d     = large_q;
    rem_d       = rem_q;
    div_sh_d    = div_sh_q;
    div_cnt_d   = div_cnt_q;
    keep_d      = keep_q;
    cnt_d       = cnt_q;
    len0_d      = len0_q;
    hit_d       = hit_q;
    hit_full_d  = hit_full_q;
    hit_ent_d   = hit_ent_q;
    hit_ofs_d   = hit_ofs_q;
    found_d     = found_q;
    unused_d    = unused_q;
    in_use_d    = in_use_q;
    total_d     = total_q;
    free_ctl    = '{op: OP_HOLD, inj: free_head};
    full_ctl    = '{op: OP_HOLD, inj: full_head};
    out_load    = 1'b0;
    res_ok      = 1'b1;
    res_slot    = '0;
    res_ofs     = '0;
    res_large   = 1'b0;
    res_free    = 9'(free_len_nx);
    res_full    = 9'(full_len_nx);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          raw_d      = request_bytes_i;
          keep_d     = keep_blocks_i;
          cnt_d      = '0;
          len0_d     = free_len;
          hit_d      = 1'b0;
          hit_full_d = 1'b0;
          found_d    = 1'b0;
          rem_d      = '0;
          div_sh_d   = request_bytes_i[15:0];
          div_cnt_d  = '0;
          size_d     = '0;
          if (action_i) begin
            state_d = ST_REL_A;
          end else if (request_bytes_i > {16'd0, bs_q}) begin
            large_d = 1'b1;
            state_d = ST_SCAN;
          end else begin
            large_d = 1'b0;
            state_d = ST_ROUND;
          end
        end
      end

      // Restoring remainder of the request by the alignment, one bit a cycle.
      ST_ROUND: begin
        rem_d     = (div_t >= {1'b0, al}) ? div_t - {1'b0, al} : div_t;
        div_sh_d  = {div_sh_q[14:0], 1'b0};
        div_cnt_d = div_cnt_q + 4'd1;
        if (div_cnt_q == 4'd15) state_d = ST_SIZE;
      end

      ST_SIZE: begin
        size_d  = 17'(raw_q[15:0]) + ((rem_q != 10'd0) ? 17'(al - rem_q[8:0]) : 17'd0);
        state_d = ST_SCAN;
      end

      // Unless oversized, rotate the free list once around, checking the head each cycle; in parallel walk
      // the usage bits for the lowest unused slot.
      ST_SCAN: begin
        if (!big && (cnt_q < len0_q)) begin
          if (!hit_q && ({1'b0, free_head.rem} >= size_q)) begin
            hit_d     = 1'b1;
            hit_ent_d = mod_ent;
            hit_ofs_d = free_head.ofs;
            if (new_rem <= slop_q) begin
              hit_full_d   = 1'b1;
              free_ctl.op  = OP_POP;
            end else begin
              free_ctl.op  = OP_ROTATE;
              free_ctl.inj = mod_ent;
            end
          end else begin
            free_ctl.op  = OP_ROTATE;
            free_ctl.inj = free_head;
          end
        end
        if (!found_q && !in_use_q[cnt_q[SW-1:0]]) begin
          found_d  = 1'b1;
          unused_d = cnt_q[SW-1:0];
        end
        cnt_d = cnt_q + LENW'(1);
        if (cnt_q == LENW'(MAX_BLOCKS - 1)) state_d = ST_PLACE;
      end

      ST_PLACE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (hit_q) begin
            if (hit_full_q) begin
              full_ctl.op  = OP_PUSH_FRONT;
              full_ctl.inj = hit_ent_q;
            end
            total_d  = total_add;
            res_slot = hit_ent_q.slot;
            res_ofs  = hit_ofs_q;
          end else if (!found_q) begin
            res_ok = 1'b0;
          end else begin
            total_d            = total_add;
            in_use_d[unused_q] = 1'b1;
            res_slot           = 8'(unused_q);
            if (big) begin
              res_large    = 1'b1;
              full_ctl.op  = OP_PUSH_FRONT;
              full_ctl.inj = '{slot: 8'(unused_q), ofs: '0, rem: '0, std: 1'b0};
            end else if (std_rem <= slop_q) begin
              full_ctl.op  = OP_PUSH_FRONT;
              full_ctl.inj = '{slot: 8'(unused_q), ofs: size_q[15:0], rem: std_rem, std: 1'b1};
            end else begin
              free_ctl.op  = OP_PUSH_FRONT;
              free_ctl.inj = '{slot: 8'(unused_q), ofs: size_q[15:0], rem: std_rem, std: 1'b1};
            end
          end
          res_free = 9'(free_len_nx);
          res_full = 9'(full_len_nx);
        end
      end

      // Append the full list behind the free list, giving the walk order.
      ST_REL_A: begin
        if (full_len != '0) begin
          full_ctl.op  = OP_POP;
          free_ctl.op  = OP_APPEND;
          free_ctl.inj = full_head;
        end else begin
          state_d = ST_REL_B;
        end
      end

      // Walk: keep up to keep_blocks standard blocks by pushing them onto the full list front (reversing),
      // drop the rest.
      ST_REL_B: begin
        if (free_len != '0) begin
          free_ctl.op = OP_POP;
          if (keep_q != 9'd0 && free_head.std) begin
            full_ctl.op  = OP_PUSH_FRONT;
            full_ctl.inj = kept_ent;
            keep_d       = keep_q - 9'd1;
          end else begin
            in_use_d[free_head.slot[SW-1:0]] = 1'b0;
          end
        end else begin
          state_d = ST_REL_C;
        end
      end

      // Move the kept blocks back as the new free list, order kept.
      ST_REL_C: begin
        if (full_len != '0) begin
          full_ctl.op  = OP_POP;
          free_ctl.op  = OP_APPEND;
          free_ctl.inj = full_head;
        end else begin
          state_d = ST_REL_DONE;
        end
      end

      ST_REL_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          total_d  = '0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_use_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      hit_full_q  <= 1'b0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      hit_full_q  <= hit_full_d;
      found_q     <= found_d;
      cnt_q       <= cnt_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_d_hold: begin
      raw_q     <= raw_d;
      size_q    <= size_d;
      large_q   <= large_d;
      rem_q     <= rem_d;
      div_sh_q  <= div_sh_d;
      keep_q    <= keep_d;
      len0_q    <= len0_d;
      hit_ent_q <= hit_ent_d;
      hit_ofs_q <= hit_ofs_d;
      unused_q  <= unused_d;
    end
    if (out_load) begin
      ok_q        <= res_ok;
      slot_q      <= res_slot;
      ofs_q       <= res_ofs;
      large_out_q <= res_large;
      free_cnt_q  <= res_free;
      full_cnt_q  <= res_full;
      total_out_q <= total_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = ok_q;
  assign block_slot_o      = slot_q;
  assign byte_offset_o     = ofs_q;
  assign is_large_o        = large_out_q;
  assign free_count_o      = free_cnt_q;
  assign full_count_o      = full_cnt_q;
  assign allocated_total_o = total_out_q;

`ifndef SYNTH
  // Between items the count of used slots equals the summed lengths of the two lists.
  a_lists_match_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |->
      ($countones(in_use_q) == (int'(free_len) + int'(full_len))))
    else $error("list lengths disagree with slot usage");

  // A refusal only happens with every slot taken.
  a_refuse_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o && state_q == ST_IDLE) |-> (&in_use_q))
    else $error("allocation refused while a slot was unused");

  // A first-fit hit is never lost before the item finishes.
  a_hit_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && hit_q) |=> hit_q)
    else $error("first-fit hit dropped mid-item");
`endif

endmodule
